### rtl/png_scanline_unfilter_assert.svh
// assertion macros shared by the unfilter block
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PSU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbl failed");

// next-cycle implication, checked out of reset
`define PSU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbl failed");

`endif

### rtl/psu_pkg.sv
// shared types and constants for the scanline unfilter
package psu_pkg;

    localparam int MAX_ROW_PIXELS = 4096;
    localparam int MAX_CHANNELS   = 4;
    localparam int STORE_DEPTH    = MAX_ROW_PIXELS * MAX_CHANNELS;
    localparam int POS_W          = $clog2(STORE_DEPTH);
    localparam int LEN_W          = POS_W + 1;
    localparam int BPP_W          = 3;
    localparam int RP_W           = 13;
    localparam int CH_W           = 2;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_AW        = $clog2(FIFO_DEPTH);

    // filter type codes
    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    // configuration register indexes
    localparam logic CFG_BPP        = 1'b0;
    localparam logic CFG_ROW_PIXELS = 1'b1;

    typedef struct packed {
        logic             bad;
        logic [7:0]       data;
        logic [2:0]       filter;
        logic             first_row;
        logic             row_first;
        logic [CH_W-1:0]  ch;
        logic [POS_W-1:0] idx;
        logic             row_end;
    } entry_t;

endpackage

### rtl/png_scanline_unfilter.sv
// an item passes the queue, the b1 register and the output register before its result is valid
// one item per cycle unless the output stalls, set by one line store read and one write per byte
// filter-type bytes that are valid are taken as input and give no result
// reset clears framing, queue and output state; the line store is not cleared
// and its read data is ignored in the first row of a pass, so no clearing pass runs
module png_scanline_unfilter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        new_pass,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  pixel_byte,
    output logic [1:0]  channel,
    output logic        row_end,
    output logic        bad_filter,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);
    import psu_pkg::*;

`include "png_scanline_unfilter_assert.svh"

    logic [BPP_W-1:0] bpp_reg;
    logic [RP_W-1:0]  rp_reg;
    logic             in_accept;
    logic             push;
    entry_t           push_entry;
    entry_t           head;
    logic             fifo_empty, fifo_full;
    logic             pop;

    assign cfg_ready = 1'b1;
    assign in_ready  = !fifo_full;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg <= BPP_W'(MAX_CHANNELS);
            rp_reg  <= RP_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BPP:        bpp_reg <= cfg_data[BPP_W-1:0];
                CFG_ROW_PIXELS: rp_reg  <= cfg_data[RP_W-1:0];
                default:        rp_reg  <= rp_reg;
            endcase
        end
    end

    psu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .data_byte  (data_byte),
        .new_pass   (new_pass),
        .bpp_cfg    (bpp_reg),
        .rp_cfg     (rp_reg),
        .push       (push),
        .push_entry (push_entry)
    );

    psu_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (fifo_empty),
        .full       (fifo_full)
    );

    psu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (fifo_empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_byte (pixel_byte),
        .channel    (channel),
        .row_end    (row_end),
        .bad_filter (bad_filter)
    );

    `PSU_ASSERT_IMP(a_fifo_state, fifo_full, !fifo_empty)
    `PSU_ASSERT_NEXT(a_push_lands, push, !fifo_empty)
    `PSU_ASSERT_IMP(a_bad_clean, out_valid && bad_filter, {pixel_byte, channel, row_end} == 11'd0)

endmodule

### rtl/psu_ram.sv
// generic single write port, single read port ram with registered read
module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/psu_fifo.sv
// short queue of classified items between front and back
module psu_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  psu_pkg::entry_t push_entry,
    input  logic            pop,
    output psu_pkg::entry_t head,
    output logic            empty,
    output logic            full
);
    import psu_pkg::*;

    entry_t             slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### rtl/psu_front.sv
// front end: row framing, filter byte handling and item classification
module psu_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [7:0]               data_byte,
    input  logic                     new_pass,
    input  logic [psu_pkg::BPP_W-1:0] bpp_cfg,
    input  logic [psu_pkg::RP_W-1:0]  rp_cfg,
    output logic                     push,
    output psu_pkg::entry_t          push_entry
);
    import psu_pkg::*;

    logic             awaiting_reg, awaiting_next;
    logic             first_row_reg, first_row_next;
    logic [2:0]       filter_reg, filter_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [1:0]       mod3_reg, mod3_next;

    logic             awaiting, first_row;
    logic [POS_W-1:0] pos;
    logic [1:0]       mod3;
    logic [BPP_W-1:0] bpp;
    logic [RP_W-1:0]  rp;
    logic [LEN_W-1:0] row_len;
    logic [LEN_W-1:0] pos_inc;
    logic [CH_W-1:0]  ch;
    logic             last;

    // clamp out-of-range register values
    always_comb
    begin
        if (bpp_cfg == '0)
        begin
            bpp = BPP_W'(1);
        end
        else if (bpp_cfg > BPP_W'(MAX_CHANNELS))
        begin
            bpp = BPP_W'(MAX_CHANNELS);
        end
        else
        begin
            bpp = bpp_cfg;
        end
        if (rp_cfg == '0)
        begin
            rp = RP_W'(1);
        end
        else if (rp_cfg > RP_W'(MAX_ROW_PIXELS))
        begin
            rp = RP_W'(MAX_ROW_PIXELS);
        end
        else
        begin
            rp = rp_cfg;
        end
    end

    assign row_len = LEN_W'(rp) * LEN_W'(bpp);

    // a pass start restarts framing before the item is looked at
    assign awaiting  = new_pass | awaiting_reg;
    assign first_row = new_pass | first_row_reg;
    assign pos       = new_pass ? '0 : pos_reg;
    assign mod3      = new_pass ? 2'd0 : mod3_reg;
    assign pos_inc   = LEN_W'(pos) + 1'b1;
    assign last      = (pos_inc >= row_len);

    always_comb
    begin
        case (bpp)
            3'd2:    ch = {1'b0, pos[0]};
            3'd3:    ch = mod3;
            3'd4:    ch = pos[1:0];
            default: ch = '0;
        endcase
    end

    always_comb
    begin
        awaiting_next  = awaiting_reg;
        first_row_next = first_row_reg;
        filter_next    = filter_reg;
        pos_next       = pos_reg;
        mod3_next      = mod3_reg;
        push           = 1'b0;

        push_entry.bad       = 1'b0;
        push_entry.data      = data_byte;
        push_entry.filter    = filter_reg;
        push_entry.first_row = first_row;
        push_entry.row_first = (pos == '0);
        push_entry.ch        = ch;
        push_entry.idx       = pos;
        push_entry.row_end   = last;

        if (accept)
        begin
            if (awaiting)
            begin
                awaiting_next  = 1'b0;
                first_row_next = first_row;
                pos_next       = '0;
                mod3_next      = 2'd0;
                if (data_byte > 8'(FILT_PAETH))
                begin
                    filter_next    = FILT_NONE;
                    push           = 1'b1;
                    push_entry.bad = 1'b1;
                end
                else
                begin
                    filter_next = data_byte[2:0];
                end
            end
            else
            begin
                push = 1'b1;
                if (last)
                begin
                    pos_next       = '0;
                    mod3_next      = 2'd0;
                    awaiting_next  = 1'b1;
                    first_row_next = 1'b0;
                end
                else
                begin
                    pos_next       = pos_inc[POS_W-1:0];
                    mod3_next      = (mod3 == 2'd2) ? 2'd0 : mod3 + 2'd1;
                    awaiting_next  = 1'b0;
                    first_row_next = first_row;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg  <= 1'b1;
            first_row_reg <= 1'b1;
            filter_reg    <= FILT_NONE;
            pos_reg       <= '0;
            mod3_reg      <= 2'd0;
        end
        else
        begin
            awaiting_reg  <= awaiting_next;
            first_row_reg <= first_row_next;
            filter_reg    <= filter_next;
            pos_reg       <= pos_next;
            mod3_reg      <= mod3_next;
        end
    end

endmodule

### rtl/psu_back.sv
// back end: line store read, prediction, reconstruction and output register
module psu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  psu_pkg::entry_t head,
    input  logic            empty,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      pixel_byte,
    output logic [1:0]      channel,
    output logic            row_end,
    output logic            bad_filter
);
    import psu_pkg::*;

    entry_t           b1_reg;
    logic             b1_valid_reg, b1_valid_next;
    logic             byp_reg;
    logic [7:0]       byp_data_reg;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       pixel_reg;
    logic [1:0]       channel_reg;
    logic             row_end_reg;
    logic             bad_reg;
    logic [7:0]       left_reg  [MAX_CHANNELS];
    logic [7:0]       upper_reg [MAX_CHANNELS];

    logic             advance;
    logic             ram_we;
    logic [7:0]       rdata;
    logic [7:0]       a, b, c, pred, x;
    logic signed [9:0] pa, pb, pc;
    logic [8:0]       abs_a, abs_b, abs_c;
    logic [8:0]       avg_sum;

    assign advance = b1_valid_reg && (!out_valid_reg || out_ready);
    assign pop     = !empty && (!b1_valid_reg || advance);
    assign ram_we  = advance && !b1_reg.bad;

    psu_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (b1_reg.idx),
        .wdata (x),
        .re    (pop && !head.bad),
        .raddr (head.idx),
        .rdata (rdata)
    );

    // a and c are zero on the first pixel bytes of a row
    assign a = b1_reg.row_first ? 8'd0 : left_reg[b1_reg.ch];
    assign c = b1_reg.row_first ? 8'd0 : upper_reg[b1_reg.ch];
    assign b = b1_reg.first_row ? 8'd0 : (byp_reg ? byp_data_reg : rdata);

    // paeth distances: |b-c|, |a-c|, |a+b-2c|
    assign pa = 10'(signed'({2'b00, b})) - 10'(signed'({2'b00, c}));
    assign pb = 10'(signed'({2'b00, a})) - 10'(signed'({2'b00, c}));
    assign pc = pa + pb;
    assign abs_a   = pa[9] ? 9'(-pa) : 9'(pa);
    assign abs_b   = pb[9] ? 9'(-pb) : 9'(pb);
    assign abs_c   = pc[9] ? 9'(-pc) : 9'(pc);
    assign avg_sum = {1'b0, a} + {1'b0, b};

    always_comb
    begin
        case (b1_reg.filter)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH:
            begin
                if (abs_a <= abs_b && abs_a <= abs_c)
                begin
                    pred = a;
                end
                else if (abs_b <= abs_c)
                begin
                    pred = b;
                end
                else
                begin
                    pred = c;
                end
            end
            default:    pred = 8'd0;
        endcase
    end

    assign x = b1_reg.data + pred;

    always_comb
    begin
        b1_valid_next = b1_valid_reg;
        if (pop)
        begin
            b1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            b1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                left_reg[i]  <= 8'd0;
                upper_reg[i] <= 8'd0;
            end
        end
        else
        begin
            b1_valid_reg  <= b1_valid_next;
            out_valid_reg <= out_valid_next;
            if (ram_we)
            begin
                for (int i = 0; i < MAX_CHANNELS; i++)
                begin
                    if (CH_W'(i) == b1_reg.ch)
                    begin
                        left_reg[i]  <= x;
                        upper_reg[i] <= b;
                    end
                    else if (b1_reg.row_first)
                    begin
                        left_reg[i]  <= 8'd0;
                        upper_reg[i] <= 8'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b1_reg <= head;
            // the write leaving this edge is not yet seen by the read
            byp_reg      <= ram_we && (b1_reg.idx == head.idx);
            byp_data_reg <= x;
        end
        if (advance)
        begin
            pixel_reg   <= b1_reg.bad ? 8'd0 : x;
            channel_reg <= b1_reg.bad ? 2'd0 : b1_reg.ch;
            row_end_reg <= b1_reg.bad ? 1'b0 : b1_reg.row_end;
            bad_reg     <= b1_reg.bad;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_byte = pixel_reg;
    assign channel    = channel_reg;
    assign row_end    = row_end_reg;
    assign bad_filter = bad_reg;

endmodule

### tb/tb_png_scanline_unfilter.sv
// testbench for the png scanline unfilter checked against a byte-level predictor
`timescale 1ns / 1ps

module tb_png_scanline_unfilter;

    import psu_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PERCENT  = 37;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [7:0] pixel;
        logic [1:0] ch;
        logic       last;
        logic       bad;
    } pixel_result_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte  = 8'h00;
    logic        new_pass   = 1'b0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [7:0]  pixel_byte;
    logic [1:0]  channel;
    logic        row_end;
    logic        bad_filter;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic        cfg_index  = CFG_BPP;
    logic [12:0] cfg_data   = 13'h0000;

    // predictor state
    logic [7:0]  line_store [STORE_DEPTH];
    logic [7:0]  left_px [MAX_CHANNELS];
    logic [7:0]  up_left_px [MAX_CHANNELS];
    logic [2:0]  cur_filter  = FILT_NONE;
    int          byte_pos    = 0;
    logic        want_filter = 1'b1;
    logic        top_row     = 1'b1;
    logic [2:0]  bpp_setting = 3'd4;
    logic [12:0] rp_setting  = 13'd1;

    pixel_result_t pending_pixels[$];

    int  error_count     = 0;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  bad_seen        = 0;
    int  cycle_count     = 0;
    int  hold_request    = 0;
    int  hold_left       = 0;
    bit  sender_calm     = 1'b0;
    bit  receiver_calm   = 1'b0;

    png_scanline_unfilter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .new_pass   (new_pass),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_byte (pixel_byte),
        .channel    (channel),
        .row_end    (row_end),
        .bad_filter (bad_filter),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int row_bytes(input logic [2:0] bpp3, input logic [12:0] rp13);
        int b;
        int p;
        b = (bpp3 == 3'd0) ? 1 : (int'(bpp3) > MAX_CHANNELS) ? MAX_CHANNELS : int'(bpp3);
        p = (rp13 == 13'd0) ? 1 : (int'(rp13) > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : int'(rp13);
        return b * p;
    endfunction

    function automatic int paeth_pick(input int a, input int b, input int c);
        int p;
        int pa;
        int pb;
        int pc;
        p  = a + b - c;
        pa = (p > a) ? p - a : a - p;
        pb = (p > b) ? p - b : b - p;
        pc = (p > c) ? p - c : c - p;
        if (pa <= pb && pa <= pc)
            return a;
        else if (pb <= pc)
            return b;
        else
            return c;
    endfunction

    // works out the result of one accepted item, if it gives one, and queues it
    function automatic void reconstruct_byte(input logic [7:0] d, input logic np);
        int            bpp;
        int            rlen;
        int            ch;
        int            idx;
        int            a;
        int            b;
        int            c;
        int            pred;
        logic [7:0]    x;
        pixel_result_t r;
        if (np)
        begin
            top_row     = 1'b1;
            want_filter = 1'b1;
            byte_pos    = 0;
        end
        if (want_filter)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                left_px[i]    = 8'h00;
                up_left_px[i] = 8'h00;
            end
            byte_pos    = 0;
            want_filter = 1'b0;
            if (d > 8'(FILT_PAETH))
            begin
                cur_filter = FILT_NONE;
                r = '{pixel: 8'h00, ch: 2'd0, last: 1'b0, bad: 1'b1};
                pending_pixels.push_back(r);
            end
            else
                cur_filter = d[2:0];
        end
        else
        begin
            bpp  = (bpp_setting == 3'd0) ? 1 :
                   (int'(bpp_setting) > MAX_CHANNELS) ? MAX_CHANNELS : int'(bpp_setting);
            rlen = row_bytes(bpp_setting, rp_setting);
            ch   = byte_pos % bpp;
            idx  = byte_pos % STORE_DEPTH;
            a    = left_px[ch[1:0]];
            b    = top_row ? 0 : int'(line_store[idx[POS_W-1:0]]);
            c    = up_left_px[ch[1:0]];
            case (cur_filter)
                FILT_SUB:   pred = a;
                FILT_UP:    pred = b;
                FILT_AVG:   pred = (a + b) >> 1;
                FILT_PAETH: pred = paeth_pick(a, b, c);
                default:    pred = 0;
            endcase
            x = d + pred[7:0];
            line_store[idx[POS_W-1:0]] = x;
            left_px[ch[1:0]]           = x;
            up_left_px[ch[1:0]]        = b[7:0];
            r.pixel = x;
            r.ch    = ch[1:0];
            r.bad   = 1'b0;
            if (byte_pos + 1 >= rlen)
            begin
                r.last      = 1'b1;
                byte_pos    = 0;
                want_filter = 1'b1;
                top_row     = 1'b0;
            end
            else
            begin
                r.last   = 1'b0;
                byte_pos = (byte_pos + 1) & 'h3FFF;
            end
            pending_pixels.push_back(r);
        end
    endfunction

    function automatic void report_mismatch(input string what, input logic [7:0] exp_v,
                                            input logic [7:0] act_v);
        error_count++;
        $display("%0t ns: %s mismatch, expected %h actual %h", $time, what, exp_v, act_v);
    endfunction

    // tracks register writes and accepted items, checks every result
    always @(posedge clk)
    begin
        pixel_result_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_BPP)
                    bpp_setting = cfg_data[2:0];
                else
                    rp_setting = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                items_sent++;
                reconstruct_byte(data_byte, new_pass);
            end
            if (out_valid && out_ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    error_count++;
                    $display("%0t ns: result with nothing expected, pixel_byte %h bad_filter %b",
                             $time, pixel_byte, bad_filter);
                end
                else
                begin
                    got = pending_pixels.pop_front();
                    results_checked++;
                    if (got.bad)
                        bad_seen++;
                    if (pixel_byte !== got.pixel)
                        report_mismatch("pixel_byte", got.pixel, pixel_byte);
                    if (channel !== got.ch)
                        report_mismatch("channel", 8'(got.ch), 8'(channel));
                    if (row_end !== got.last)
                        report_mismatch("row_end", 8'(got.last), 8'(row_end));
                    if (bad_filter !== got.bad)
                        report_mismatch("bad_filter", 8'(got.bad), 8'(bad_filter));
                end
            end
        end
    end

    // receiver: random stalls, always ready when calm, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (receiver_calm)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    task send_byte(input logic [7:0] d, input logic np);
        while (!sender_calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= d;
        new_pass  <= np;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // filter byte followed by nbytes random data bytes
    task send_row(input logic [7:0] filt, input logic np, input int nbytes);
        send_byte(filt, np);
        repeat (nbytes)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task drain_results;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_reg(input logic idx, input logic [12:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // reset values: four channels, one pixel per row
    task test_power_on_settings;
        send_byte(8'(FILT_PAETH), 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_row(8'(FILT_UP), 1'b0, 4);
        drain_results();
    endtask

    task test_each_filter;
        write_reg(CFG_BPP, 13'd2);
        write_reg(CFG_ROW_PIXELS, 13'd2);
        send_byte(8'(FILT_NONE), 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'(FILT_SUB), 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'(FILT_UP), 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'(FILT_AVG), 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'(FILT_PAETH), 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        drain_results();
    endtask

    // out-of-range filter bytes, then a pass restarted in the middle of a row
    task test_bad_filter_byte;
        write_reg(CFG_BPP, 13'd1);
        write_reg(CFG_ROW_PIXELS, 13'd3);
        send_row(8'(FILT_PAETH) + 8'd1, 1'b1, 3);
        send_row(8'hFF, 1'b0, 3);
        send_row(8'(FILT_UP), 1'b0, 1);
        send_row(8'(FILT_PAETH), 1'b1, 3);
        send_row(8'(FILT_AVG), 1'b0, 3);
        drain_results();
    endtask

    task test_register_clamping;
        write_reg(CFG_BPP, 13'd0);
        write_reg(CFG_ROW_PIXELS, 13'd0);
        send_row(8'(FILT_SUB), 1'b1, 1);
        send_row(8'(FILT_UP), 1'b0, 1);
        send_row(8'(FILT_PAETH), 1'b0, 1);
        drain_results();
        write_reg(CFG_BPP, 13'd7);
        write_reg(CFG_ROW_PIXELS, 13'd3);
        send_row(8'(FILT_AVG), 1'b1, 12);
        send_row(8'(FILT_PAETH), 1'b0, 12);
        drain_results();
    endtask

    // shrink the row and change the pixel size while a row is half done
    task test_mid_row_reconfig;
        write_reg(CFG_BPP, 13'd4);
        write_reg(CFG_ROW_PIXELS, 13'd8);
        send_row(8'(FILT_SUB), 1'b1, 10);
        drain_results();
        write_reg(CFG_BPP, 13'd3);
        write_reg(CFG_ROW_PIXELS, 13'd2);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_row(8'(FILT_AVG), 1'b0, 6);
        send_row(8'(FILT_PAETH), 1'b0, 6);
        drain_results();
    endtask

    task test_output_backpressure;
        write_reg(CFG_BPP, 13'd3);
        write_reg(CFG_ROW_PIXELS, 13'd5);
        hold_request = HOLD_CYCLES;
        send_row(8'(FILT_PAETH), 1'b1, 15);
        send_row(8'(FILT_AVG), 1'b0, 15);
        send_row(8'(FILT_UP), 1'b0, 15);
        send_row(8'(FILT_SUB), 1'b0, 15);
        // sender stops until the block has caught up
        drain_results();
        send_row(8'(FILT_UP), 1'b0, 15);
        send_row(8'(FILT_AVG), 1'b0, 15);
        drain_results();
    endtask

    task test_random_passes;
        int          target;
        int          row_count;
        int          rlen;
        int          cut;
        int          k;
        logic [2:0]  bpp3;
        logic [12:0] rp13;
        logic [12:0] hi;
        logic [7:0]  filt;
        logic        fresh_pass;
        target        = items_sent + 150;
        sender_calm   = 1'b1;
        receiver_calm = 1'b1;
        while (items_sent < target)
        begin
            // first stretch runs without idling
            if (items_sent > target - 80)
            begin
                sender_calm   = 1'b0;
                receiver_calm = 1'b0;
            end
            drain_results();
            k = $urandom_range(0, 99);
            if (k < 80)
                bpp3 = 3'($urandom_range(1, 4));
            else
            begin
                k    = $urandom_range(0, 3);
                bpp3 = (k == 0) ? 3'd0 : 3'd4 + k[2:0];
            end
            hi = 13'($urandom_range(0, 1023));
            write_reg(CFG_BPP, {hi[9:0], bpp3});
            k = $urandom_range(0, 99);
            if (k < 5)
                rp13 = 13'd0;
            else if (k < 90)
                rp13 = 13'($urandom_range(1, 6));
            else
                rp13 = 13'($urandom_range(7, 40));
            write_reg(CFG_ROW_PIXELS, rp13);
            rlen       = row_bytes(bpp3, rp13);
            row_count  = $urandom_range(1, 6);
            fresh_pass = 1'b1;
            for (int r = 0; r < row_count; r++)
            begin
                if ($urandom_range(0, 99) < 90)
                    filt = 8'($urandom_range(FILT_NONE, FILT_PAETH));
                else
                    filt = 8'($urandom_range(FILT_PAETH + 1, 255));
                if ($urandom_range(0, 99) < 4)
                    fresh_pass = 1'b1;
                // now and then a row is cut short and the pass restarts
                cut = ($urandom_range(0, 99) < 5) ? int'($urandom_range(0, rlen - 1)) : rlen;
                send_row(filt, fresh_pass, cut);
                fresh_pass = (cut != rlen);
            end
        end
        drain_results();
    endtask

    // row_pixels above MAX_ROW_PIXELS clamped and bpp upper bits ignored; rows cut short by a new pass
    task test_widest_row;
        write_reg(CFG_BPP, 13'h1FF9);
        write_reg(CFG_ROW_PIXELS, 13'h1FFF);
        send_row(8'(FILT_SUB), 1'b1, 24);
        send_row(8'(FILT_PAETH), 1'b1, 24);
        drain_results();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_power_on_settings();
        test_each_filter();
        test_bad_filter_byte();
        test_register_clamping();
        test_mid_row_reconfig();
        test_output_backpressure();
        test_random_passes();
        test_widest_row();
        drain_results();
        $display("covered %0d input items, %0d results, %0d bad filter bytes, all filters,",
                 items_sent, results_checked, bad_seen);
        $display("register extremes, mid-row changes, a long output hold-off and random passes");
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
